// ===== design/ciphps_pkg.sv =====
// ----------------------------------------------------------------------------
// Client IP hash peer select - shared definitions
// Constants, codes and field widths used by the selection unit and its parts.
// ----------------------------------------------------------------------------
package ciphps_pkg;

  localparam int MAX_PEERS_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam int MAX_TRIES_DEF   = 20;

  localparam int unsigned HASH_MUL  = 113;
  localparam int unsigned HASH_MOD  = 6271;
  localparam int unsigned HASH_SEED = 89;
  localparam int HASH_W      = 13;
  localparam int PROD_W      = 20;
  localparam int QUO_W       = 7;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 20;
  localparam longint unsigned HASH_RECIP = (64'd1 << RECIP_SHIFT) / HASH_MOD;

  localparam int CFG_W        = 6;
  localparam int KIND_W       = 2;
  localparam int IDX_W        = 5;
  localparam int WIN_W        = 8;
  localparam int FAM_W        = 2;
  localparam int ADDR_W       = 64;
  localparam int MASK_W       = 32;
  localparam int IN_DATA_W    = 176;
  localparam int OUT_DATA_W   = 8;
  localparam int BYTE_CNT_W   = 5;
  localparam int BYTE_IDX_W   = 4;
  localparam int ADDR_BYTES_V4 = 3;
  localparam int ADDR_BYTES_V6 = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_START  = 2'd1,
    KIND_PICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [FAM_W-1:0] {
    FAM_IPV4  = 2'd0,
    FAM_IPV6  = 2'd1,
    FAM_OTHER = 2'd2,
    FAM_RSVD  = 2'd3
  } family_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_FALLBACK = 2'd2,
    ST_ACK      = 2'd3
  } status_t;

endpackage

// ===== design/ciphps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ciphps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ciphps_fold.sv =====
// ----------------------------------------------------------------------------
// Hash fold step
// h' = (h*113 + b) mod 6271 in three stages: product, reciprocal quotient,
// subtract with one correction.
// ----------------------------------------------------------------------------
module ciphps_fold (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ciphps_pkg::HASH_W-1:0] h_in,
  input  logic [7:0]                   byte_in,
  output logic                         done,
  output logic [ciphps_pkg::HASH_W-1:0] h_out
);

  localparam int PW = ciphps_pkg::PROD_W;
  localparam int FW = ciphps_pkg::PROD_W + ciphps_pkg::RECIP_W;

  logic                          v1_r, v2_r, done_r;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic [ciphps_pkg::QUO_W-1:0]  q_r, q_nxt;
  logic [ciphps_pkg::HASH_W-1:0] h_r, h_nxt;
  logic [FW-1:0]                 full;
  logic [PW-1:0]                 diff;

  always_comb begin
    prod_nxt = PW'(h_in) * PW'(ciphps_pkg::HASH_MUL) + PW'(byte_in);
    full     = FW'(prod_r) * FW'(ciphps_pkg::HASH_RECIP);
    q_nxt    = full[ciphps_pkg::RECIP_SHIFT +: ciphps_pkg::QUO_W];
    diff     = prod_r - PW'(q_r) * PW'(ciphps_pkg::HASH_MOD);
    if (diff >= PW'(ciphps_pkg::HASH_MOD)) begin
      h_nxt = ciphps_pkg::HASH_W'(diff - PW'(ciphps_pkg::HASH_MOD));
    end else begin
      h_nxt = ciphps_pkg::HASH_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
    end
    if (v1_r) begin
      q_r <= q_nxt;
    end
    if (v2_r) begin
      h_r <= h_nxt;
    end
  end

  assign done  = done_r;
  assign h_out = h_r;

endmodule

// ===== design/ciphps_rem.sv =====
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ciphps_rem #(
  parameter int NUM_W = 13,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DEN_W-1:0] remainder
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[NUM_W-1]};
    if (start) begin
      cnt_nxt = CW'(NUM_W);
      num_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
      num_nxt  = num_r << 1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = DEN_W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== design/client_ip_hash_peer_select_unit.sv =====
// ----------------------------------------------------------------------------
// Client IP hash peer select unit
// Picks a backend peer from a hash of the client address and peer weights.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out; items are handled one at a
// time, and a new item is taken while the previous result still waits on the
// output. A weight write, and a peer_count write, rescan the weight memory
// one entry per cycle over the peers in use; a peer_count write returns
// nothing. A request start, an unknown kind, or a pick that ends busy or
// fall back goes straight to the response. A pick that hashes, per try,
// folds each address byte into the hash (3 bytes for IPv4 and others, 16
// for IPv6), runs the bit-serial remainder unit, and walks the peers
// through the single read port of the weight memory, up to MAX_TRIES+1
// tries. No clearing pass after reset.
// ----------------------------------------------------------------------------
module client_ip_hash_peer_select_unit #(
  parameter int MAX_PEERS   = ciphps_pkg::MAX_PEERS_DEF,
  parameter int WEIGHT_BITS = ciphps_pkg::WEIGHT_BITS_DEF,
  parameter int MAX_TRIES   = ciphps_pkg::MAX_TRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // peer_index[4:0], weight[12:5], family[14:13], addr_high[78:15],
  // addr_low[142:79], available_mask[174:143], zero[175]
  input  logic [ciphps_pkg::IN_DATA_W-1:0] in_tdata,
  // kind[1:0]
  input  logic [ciphps_pkg::KIND_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // chosen_peer[4:0], zero[7:5]
  output logic [ciphps_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ciphps_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PEER_W = $clog2(MAX_PEERS);
  localparam int CNT_W  = $clog2(MAX_PEERS + 1);
  localparam int SUM_W  = WEIGHT_BITS + PEER_W;
  localparam int TRY_W  = $clog2(MAX_TRIES + 2);
  localparam int HW     = ciphps_pkg::HASH_W;
  localparam int BCW    = ciphps_pkg::BYTE_CNT_W;
  localparam int BIW    = ciphps_pkg::BYTE_IDX_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SUM_RD = 7'b0000010,
    S_SUM    = 7'b0000100,
    S_FOLD   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  // input fields
  logic [ciphps_pkg::IDX_W-1:0]  f_idx;
  logic [ciphps_pkg::WIN_W-1:0]  f_weight;
  logic [ciphps_pkg::FAM_W-1:0]  f_family;
  logic [ciphps_pkg::ADDR_W-1:0] f_addr_high, f_addr_low;
  logic [ciphps_pkg::MASK_W-1:0] f_avail;

  assign f_idx       = in_tdata[4:0];
  assign f_weight    = in_tdata[12:5];
  assign f_family    = in_tdata[14:13];
  assign f_addr_high = in_tdata[78:15];
  assign f_addr_low  = in_tdata[142:79];
  assign f_avail     = in_tdata[174:143];

  state_t                        state_r, state_nxt;
  logic [ciphps_pkg::CFG_W-1:0]  peer_count_r, peer_count_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [HW-1:0]                 run_hash_r, run_hash_nxt;
  logic [MAX_PEERS-1:0]          tried_r, tried_nxt;
  logic [TRY_W-1:0]              try_cnt_r, try_cnt_nxt;
  logic [127:0]                  addr_r, addr_nxt;
  logic [BCW-1:0]                byte_cnt_r, byte_cnt_nxt;
  logic                          sweep_ack_r, sweep_ack_nxt;
  logic                          fold_wait_r, fold_wait_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [ciphps_pkg::MASK_W-1:0] avail_r, avail_nxt;
  logic [HW-1:0]                 h_work_r, h_work_nxt;
  logic [BIW-1:0]                bidx_r, bidx_nxt;
  logic [PEER_W-1:0]             sidx_r, sidx_nxt;
  logic [SUM_W-1:0]              w_r, w_nxt;
  logic [PEER_W-1:0]             p_r, p_nxt;
  ciphps_pkg::status_t           res_status_r, res_status_nxt;
  logic [4:0]                    res_peer_r, res_peer_nxt;
  ciphps_pkg::status_t           out_status_r, out_status_nxt;
  logic [4:0]                    out_peer_r, out_peer_nxt;

  logic [CNT_W-1:0]  n_use;
  logic              in_acc, cfg_acc;
  logic              ram_we;
  logic [PEER_W-1:0] ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;
  logic [SUM_W-1:0]  wt_ext;
  logic [BIW-1:0]    bsel;
  logic [7:0]        fold_byte;
  logic              fold_start, fold_done;
  logic [HW-1:0]     fold_h;
  logic              rem_start, rem_done;
  logic [SUM_W-1:0]  rem_val;
  logic [6:0]        p_wide;
  logic              peer_free;
  logic [TRY_W-1:0]  try_inc;

  assign n_use = (7'(peer_count_r) > 7'(MAX_PEERS)) ? CNT_W'(MAX_PEERS)
                                                    : CNT_W'(peer_count_r);

  assign cfg_ready = (state_r == S_IDLE);
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_tvalid && in_tready;

  assign ram_we    = in_acc && (in_tuser == ciphps_pkg::KIND_WEIGHT)
                     && (32'(f_idx) < 32'(MAX_PEERS));
  assign ram_waddr = PEER_W'(f_idx);
  assign ram_wdata = WEIGHT_BITS'(f_weight);
  assign wt_ext    = SUM_W'(ram_rdata);

  assign bsel      = BIW'(ciphps_pkg::ADDR_BYTES_V6 - 1) - bidx_r;
  assign fold_byte = addr_r[{bsel, 3'b000} +: 8];
  assign p_wide    = 7'(p_r);
  assign peer_free = !tried_r[p_r] && (p_wide < 7'd32) && avail_r[p_wide[4:0]];
  assign try_inc   = try_cnt_r + TRY_W'(1);

  always_comb begin
    case (state_r)
      S_SUM:   ram_raddr = sidx_r + PEER_W'(1);
      S_WALK:  ram_raddr = p_r + PEER_W'(1);
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    peer_count_nxt = peer_count_r;
    sum_nxt        = sum_r;
    run_hash_nxt   = run_hash_r;
    tried_nxt      = tried_r;
    try_cnt_nxt    = try_cnt_r;
    addr_nxt       = addr_r;
    byte_cnt_nxt   = byte_cnt_r;
    sweep_ack_nxt  = sweep_ack_r;
    fold_wait_nxt  = fold_wait_r;
    avail_nxt      = avail_r;
    h_work_nxt     = h_work_r;
    bidx_nxt       = bidx_r;
    sidx_nxt       = sidx_r;
    w_nxt          = w_r;
    p_nxt          = p_r;
    res_status_nxt = res_status_r;
    res_peer_nxt   = res_peer_r;
    fold_start     = 1'b0;
    rem_start      = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_peer_nxt   = out_peer_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        res_status_nxt = ciphps_pkg::ST_ACK;
        res_peer_nxt   = '0;
        if (cfg_acc) begin
          peer_count_nxt = cfg_data;
          sweep_ack_nxt  = 1'b0;
          state_nxt      = S_SUM_RD;
        end else if (in_acc) begin
          state_nxt = S_RESP;
          case (in_tuser)
            ciphps_pkg::KIND_WEIGHT: begin
              sweep_ack_nxt = 1'b1;
              state_nxt     = S_SUM_RD;
            end
            ciphps_pkg::KIND_START: begin
              case (f_family)
                ciphps_pkg::FAM_IPV4: begin
                  addr_nxt     = {f_addr_low[31:0], 96'd0};
                  byte_cnt_nxt = BCW'(ciphps_pkg::ADDR_BYTES_V4);
                end
                ciphps_pkg::FAM_IPV6: begin
                  addr_nxt     = {f_addr_high, f_addr_low};
                  byte_cnt_nxt = BCW'(ciphps_pkg::ADDR_BYTES_V6);
                end
                default: begin
                  addr_nxt     = '0;
                  byte_cnt_nxt = BCW'(ciphps_pkg::ADDR_BYTES_V4);
                end
              endcase
              run_hash_nxt = HW'(ciphps_pkg::HASH_SEED);
              tried_nxt    = '0;
              try_cnt_nxt  = '0;
            end
            ciphps_pkg::KIND_PICK: begin
              if (n_use == '0 || sum_r == '0) begin
                res_status_nxt = ciphps_pkg::ST_BUSY;
              end else if (try_cnt_r > TRY_W'(MAX_TRIES) || n_use == CNT_W'(1)) begin
                res_status_nxt = ciphps_pkg::ST_FALLBACK;
              end else begin
                avail_nxt     = f_avail;
                h_work_nxt    = run_hash_r;
                bidx_nxt      = '0;
                fold_wait_nxt = 1'b0;
                state_nxt     = S_FOLD;
              end
            end
            default: begin
              res_status_nxt = ciphps_pkg::ST_ACK;
            end
          endcase
        end
      end

      S_SUM_RD: begin
        sum_nxt  = '0;
        sidx_nxt = '0;
        if (n_use == '0) begin
          state_nxt = sweep_ack_r ? S_RESP : S_IDLE;
        end else begin
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        sum_nxt  = sum_r + wt_ext;
        sidx_nxt = sidx_r + PEER_W'(1);
        if (CNT_W'(sidx_r) + CNT_W'(1) == n_use) begin
          state_nxt = sweep_ack_r ? S_RESP : S_IDLE;
        end
      end

      S_FOLD: begin
        if (!fold_wait_r) begin
          fold_start    = 1'b1;
          fold_wait_nxt = 1'b1;
        end else if (fold_done) begin
          fold_wait_nxt = 1'b0;
          h_work_nxt    = fold_h;
          if (BCW'(bidx_r) + BCW'(1) == byte_cnt_r) begin
            rem_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            bidx_nxt = bidx_r + BIW'(1);
          end
        end
      end

      S_DIV: begin
        if (rem_done) begin
          w_nxt     = rem_val;
          p_nxt     = '0;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (CNT_W'(p_r) + CNT_W'(1) < n_use && w_r >= wt_ext) begin
          w_nxt = w_r - wt_ext;
          p_nxt = p_r + PEER_W'(1);
        end else if (peer_free) begin
          tried_nxt[p_r] = 1'b1;
          run_hash_nxt   = h_work_r;
          res_status_nxt = ciphps_pkg::ST_OK;
          res_peer_nxt   = p_wide[4:0];
          state_nxt      = S_RESP;
        end else begin
          try_cnt_nxt = try_inc;
          if (try_inc > TRY_W'(MAX_TRIES)) begin
            res_status_nxt = ciphps_pkg::ST_FALLBACK;
            state_nxt      = S_RESP;
          end else begin
            bidx_nxt      = '0;
            fold_wait_nxt = 1'b0;
            state_nxt     = S_FOLD;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_peer_nxt   = res_peer_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      peer_count_r <= '0;
      sum_r        <= '0;
      run_hash_r   <= HW'(ciphps_pkg::HASH_SEED);
      tried_r      <= '0;
      try_cnt_r    <= '0;
      addr_r       <= '0;
      byte_cnt_r   <= BCW'(ciphps_pkg::ADDR_BYTES_V4);
      sweep_ack_r  <= 1'b0;
      fold_wait_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      peer_count_r <= peer_count_nxt;
      sum_r        <= sum_nxt;
      run_hash_r   <= run_hash_nxt;
      tried_r      <= tried_nxt;
      try_cnt_r    <= try_cnt_nxt;
      addr_r       <= addr_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      sweep_ack_r  <= sweep_ack_nxt;
      fold_wait_r  <= fold_wait_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avail_r      <= avail_nxt;
    h_work_r     <= h_work_nxt;
    bidx_r       <= bidx_nxt;
    sidx_r       <= sidx_nxt;
    w_r          <= w_nxt;
    p_r          <= p_nxt;
    res_status_r <= res_status_nxt;
    res_peer_r   <= res_peer_nxt;
    out_status_r <= out_status_nxt;
    out_peer_r   <= out_peer_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_peer_r};
  assign out_tuser  = out_status_r;

  ciphps_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_PEERS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ciphps_fold u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (fold_start),
    .h_in    (h_work_r),
    .byte_in (fold_byte),
    .done    (fold_done),
    .h_out   (fold_h)
  );

  ciphps_rem #(
    .NUM_W (HW),
    .DEN_W (SUM_W)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (fold_h),
    .divisor   (sum_r),
    .done      (rem_done),
    .remainder (rem_val)
  );

endmodule
